@@ hw/rtl/positional_list_insert_delete_unit_macros.svh @@
// Assertion macros used by the checker file plid_checker.sv.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLID_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/plid_pkg.sv @@
package plid_pkg;

  // Field widths fixed by the item layout.
  localparam int OP_W    = 2;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 7;
  localparam int SLOT_W  = 6;
  // Width used to compare positions, indexes and counts (covers a depth of 256).
  localparam int CMP_W   = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // Cell moves applied to the whole row at once.
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_ROT  = 2'd3;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [1:0]               mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

@@ hw/rtl/plid_cell.sv @@
module plid_cell
  import plid_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CW-1:0]            count,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  input  logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0] q
);

  localparam logic [CMP_W-1:0] IDX_V  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(IDX + 1);

  logic signed [DATA_W-1:0] q_next;
  logic [CMP_W-1:0]         pos_v;
  logic [CMP_W-1:0]         count_v;

  // Pick the new entry from this cell, a neighbor, the head or the insert value.
  always_comb begin
    pos_v   = CMP_W'(ctl.pos);
    count_v = CMP_W'(count);
    q_next  = q;
    unique case (ctl.mode)
      MODE_UP: begin
        if (IDX_V > pos_v) begin
          q_next = left;
        end else if (IDX_V == pos_v) begin
          q_next = ctl.data;
        end
      end
      MODE_DOWN: begin
        if (IDX_V >= pos_v) begin
          q_next = right;
        end
      end
      MODE_ROT: begin
        // The occupied part turns left by one; the head wraps to the tail.
        if (IDX_P1 < count_v) begin
          q_next = right;
        end else if (IDX_P1 == count_v) begin
          q_next = head;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ hw/rtl/positional_list_insert_delete_unit.sv @@
// Channel  | Dir | Contents
// s_axis   | in  | op, data_in, position (one command item)
// m_axis   | out | status, fill_level, slot, data_out, with is_last on tlast
//
// Insert and delete move every cell of the row at once; the status item is
// in the output register in the cycle after the command is taken.
// Display rotates the occupied cells through the head, one item per cycle
// while the output is not stalled; no new command is taken until it ends.
// A stalled output holds the row still. Reset (rst, synchronous) empties the
// list; entry contents are not cleared and are never read before written.
module positional_list_insert_delete_unit
  import plid_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [33:2] data_in, [40:34] position, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [8:2] fill_level, [14:9] slot, [46:15] data_out, [47] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic                     state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [IW-1:0]            idx, idx_next;
  logic                     valid_next;
  logic [STAT_W-1:0]        out_status, out_status_next;
  logic [FILL_W-1:0]        out_fill, out_fill_next;
  logic [SLOT_W-1:0]        out_slot, out_slot_next;
  logic signed [DATA_W-1:0] out_data, out_data_next;
  logic                     out_last, out_last_next;

  logic [OP_W-1:0]          in_op;
  logic signed [DATA_W-1:0] in_data;
  logic [POS_W-1:0]         in_pos;
  logic                     out_free;
  logic                     take;
  logic                     show_last;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  assign in_op   = s_axis_tdata[1:0];
  assign in_data = s_axis_tdata[33:2];
  assign in_pos  = s_axis_tdata[40:34];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign show_last     = (CMP_W'(idx) + CMP_W'(1)) == CMP_W'(count);

  // Command decode, display sequencing and result loading.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    valid_next      = m_axis_tvalid && !m_axis_tready;
    out_status_next = out_status;
    out_fill_next   = out_fill;
    out_slot_next   = out_slot;
    out_data_next   = out_data;
    out_last_next   = out_last;
    ctl.mode        = MODE_HOLD;
    ctl.pos         = in_pos;
    ctl.data        = in_data;

    unique case (state)
      ST_IDLE: begin
        if (take && in_op != OP_DISPLAY && in_op != OP_INSERT && in_op != OP_DELETE) begin
          // Unused code: no change, no result.
          valid_next = 1'b0;
        end else if (take) begin
          out_status_next = ST_OK;
          out_slot_next   = '0;
          out_data_next   = '0;
          out_last_next   = 1'b1;
          valid_next      = 1'b1;
          if (in_op == OP_INSERT) begin
            if (count == CW'(DEPTH)) begin
              out_status_next = ST_FULL;
            end else if (CMP_W'(in_pos) > CMP_W'(count)) begin
              out_status_next = ST_BADPOS;
            end else begin
              ctl.mode   = MODE_UP;
              count_next = count + CW'(1);
            end
          end else if (in_op == OP_DELETE) begin
            if (count == '0) begin
              out_status_next = ST_EMPTY;
            end else if (CMP_W'(in_pos) >= CMP_W'(count)) begin
              out_status_next = ST_BADPOS;
            end else begin
              ctl.mode   = MODE_DOWN;
              count_next = count - CW'(1);
            end
          end else begin
            if (count == '0) begin
              out_status_next = ST_EMPTY;
            end else begin
              // Entries come out in the following cycles.
              valid_next = 1'b0;
              idx_next   = '0;
              state_next = ST_SHOW;
            end
          end
          out_fill_next = FILL_W'(count_next);
        end
      end
      ST_SHOW: begin
        if (out_free) begin
          ctl.mode        = MODE_ROT;
          valid_next      = 1'b1;
          out_status_next = ST_OK;
          out_fill_next   = FILL_W'(count);
          out_slot_next   = SLOT_W'(idx);
          out_data_next   = cell_q[0];
          out_last_next   = show_last;
          if (show_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      idx           <= idx_next;
      m_axis_tvalid <= valid_next;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_fill   <= out_fill_next;
    out_slot   <= out_slot_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
  end

  assign m_axis_tdata = {1'b0, out_data, out_slot, out_fill, out_status};
  assign m_axis_tlast = out_last;

  // Row of entry cells, each linked to the head and to its neighbors; the end cells see zero outside the row.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_q;
    logic signed [DATA_W-1:0] right_q;

    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[g+1];
    end

    plid_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .count (count),
      .left  (left_q),
      .right (right_q),
      .head  (cell_q[0]),
      .q     (cell_q[g])
    );
  end

endmodule

@@ hw/rtl/plid_checker.sv @@
`include "positional_list_insert_delete_unit_macros.svh"

module plid_checker
  import plid_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [STAT_W-1:0] status;
  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] data;

  assign status = m_axis_tdata[1:0];
  assign fill   = m_axis_tdata[8:2];
  assign slot   = m_axis_tdata[14:9];
  assign data   = m_axis_tdata[46:15];

  // A stalled item keeps its contents.
  `PLID_ASSERT_NEXT(a_hold,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "stalled output item changed")

  // Refusals are single items with no slot or data.
  `PLID_ASSERT_IMPLY(a_refuse,
    m_axis_tvalid && status != ST_OK,
    m_axis_tlast && slot == '0 && data == '0,
    "refusal item malformed")

  // An empty status only comes with an empty list.
  `PLID_ASSERT_IMPLY(a_empty,
    m_axis_tvalid && status == ST_EMPTY,
    fill == '0,
    "empty status with entries")

  // The reported count never exceeds the depth.
  `PLID_ASSERT_IMPLY(a_fill,
    m_axis_tvalid,
    int'(fill) <= DEPTH,
    "fill level beyond depth")

endmodule

bind positional_list_insert_delete_unit plid_checker #(.DEPTH(DEPTH)) u_plid_checker (.*);

@@ tb/sv/list_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the list unit, keeps its own copy of the list and
// compares every output item with the oldest predicted one.
module list_result_checker
  import plid_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [1:0] op, [33:2] data_in, [40:34] position, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [8:2] fill_level, [14:9] slot, [46:15] data_out, [47] zero
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending,
  output int          fill
);

  localparam int FILL_LSB = STAT_W;
  localparam int SLOT_LSB = FILL_LSB + FILL_W;
  localparam int DATA_LSB = SLOT_LSB + SLOT_W;
  localparam int POS_LSB  = OP_W + DATA_W;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_level;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } list_result_t;

  logic signed [DATA_W-1:0] row [DEPTH];
  int                       used;
  list_result_t             expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    fill       = 0;
    used       = 0;
  end

  // Queue one predicted output item; the fill level is the count after the command.
  task automatic push_result(input logic [STAT_W-1:0] status, input int slot,
                             input logic signed [DATA_W-1:0] data, input logic last);
    list_result_t r;
    r.status     = status;
    r.fill_level = used[FILL_W-1:0];
    r.slot       = slot[SLOT_W-1:0];
    r.data       = data;
    r.last       = last;
    expected_q.push_back(r);
  endtask

  // Apply one accepted command to the shadow list and predict its output items.
  task automatic apply_command(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] position);
    int p;
    p = position;
    case (op)
      OP_INSERT: begin
        // A full list is refused before the position is looked at.
        if (used >= DEPTH) begin
          push_result(ST_FULL, 0, '0, 1'b1);
        end else if (p > used) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = used; i > p; i--) row[i] = row[i-1];
          row[p] = value;
          used++;
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        // An empty list is refused before the position is looked at.
        if (used == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (p >= used) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = p; i + 1 < used; i++) row[i] = row[i+1];
          used--;
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (used == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < used; i++) push_result(ST_OK, i, row[i], i == used - 1);
        end
      end
      default: begin
        // The unused op code changes nothing and gives no output item.
      end
    endcase
  endtask

  // Compare first so that the oldest prediction is always the one checked.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      expected_q.delete();
      used = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tdata[STAT_W-1:0];
        got.fill_level = m_axis_tdata[FILL_LSB +: FILL_W];
        got.slot       = m_axis_tdata[SLOT_LSB +: SLOT_W];
        got.data       = m_axis_tdata[DATA_LSB +: DATA_W];
        got.last       = m_axis_tlast;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected item status=%0d fill=%0d slot=%0d data=%0d last=%0b",
                     $time, got.status, got.fill_level, got.slot, got.data, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch", $time);
              $display("  expected status=%0d fill=%0d slot=%0d data=%0d last=%0b",
                       want.status, want.fill_level, want.slot, want.data, want.last);
              $display("  actual   status=%0d fill=%0d slot=%0d data=%0d last=%0b",
                       got.status, got.fill_level, got.slot, got.data, got.last);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_command(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W +: DATA_W],
                      s_axis_tdata[POS_LSB +: POS_W]);
    end
    pending = expected_q.size();
    fill    = used;
  end

endmodule

@@ tb/sv/tb_positional_list_insert_delete_unit.sv @@
`timescale 1ns / 100ps

module tb_positional_list_insert_delete_unit;
  import plid_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 180;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PAD_W        = 48 - OP_W - DATA_W - POS_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX  = '1;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  wire         s_axis_tready;
  logic [47:0] s_axis_tdata;
  wire         m_axis_tvalid;
  logic        m_axis_tready;
  wire  [47:0] m_axis_tdata;
  wire         m_axis_tlast;

  int failures;
  int pending;
  int fill;
  int cycles;
  bit steady;

  positional_list_insert_delete_unit #(.DEPTH(DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  list_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (failures),
    .pending       (pending),
    .fill          (fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output back-pressure: runs of ready, then stalls that are mostly short.
  initial begin
    int run;
    int stall;
    int r;
    m_axis_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      if (r < 50) stall = 0;
      else if (r < 88) stall = $urandom_range(1, 3);
      else stall = $urandom_range(8, 40);
      repeat (run) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Idle cycles before the next command item.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Values with extra weight on the signed extremes and zero.
  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // A position from 0 to hi, with the two ends favored.
  function automatic logic [POS_W-1:0] pick_pos(input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return hi[POS_W-1:0];
    return POS_W'($urandom_range(0, hi));
  endfunction

  // Entered and left at a falling edge; valid only changes once per edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, position, value, op};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Hold the input off until every predicted item has come out.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // A command that the list accepts, given its current fill.
  task automatic send_valid_command();
    int r;
    r = $urandom_range(0, 99);
    if (fill == 0 || (r < 55 && fill < DEPTH))
      send_item(OP_INSERT, random_value(), pick_pos(fill));
    else if (r < 90)
      send_item(OP_DELETE, random_value(), pick_pos(fill - 1));
    else
      send_item(OP_DISPLAY, random_value(), POS_W'($urandom_range(0, 127)));
  endtask

  // Cycle limit for a hung run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-list cases, both refusals, ends and middle, unused op.
    send_item(OP_DISPLAY, 32'h0, 7'd0);
    send_item(OP_DELETE, 32'h0, 7'd0);
    send_item(OP_DELETE, 32'hFFFF_FFFF, POS_MAX);
    send_item(OP_INSERT, 32'h1234_5678, 7'd1);
    send_item(OP_INSERT, 32'h1234_5678, POS_MAX);
    send_item(OP_INSERT, 32'h7FFF_FFFF, 7'd0);
    send_item(OP_INSERT, 32'h8000_0000, 7'd1);
    send_item(OP_INSERT, 32'h0000_0000, 7'd0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 7'd1);
    send_item(OP_DISPLAY, 32'hFFFF_FFFF, POS_MAX);
    send_item(OP_UNUSED, 32'hA5A5_5A5A, 7'd2);
    send_item(OP_DELETE, 32'h0, 7'd4);
    send_item(OP_DELETE, 32'h0, POS_MAX);
    send_item(OP_DELETE, 32'h0, 7'd1);
    send_item(OP_DELETE, 32'h0, 7'd2);
    send_item(OP_DELETE, 32'h0, 7'd0);
    send_item(OP_DISPLAY, 32'h0, 7'd0);
    send_item(OP_INSERT, 32'h5555_AAAA, 7'd64);
    pause_until_drained();

    // Random: mostly well-formed commands, some noise, one full fill and drain.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == 100) begin
        while (fill < DEPTH) send_item(OP_INSERT, random_value(), pick_pos(fill));
        send_item(OP_INSERT, random_value(), 7'd0);
        send_item(OP_INSERT, random_value(), 7'd64);
        send_item(OP_INSERT, random_value(), POS_MAX);
        send_item(OP_DISPLAY, random_value(), POS_W'($urandom_range(0, 127)));
        while (fill > 0) send_item(OP_DELETE, random_value(), pick_pos(fill - 1));
        send_item(OP_DELETE, random_value(), POS_W'($urandom_range(0, 127)));
        send_item(OP_DISPLAY, random_value(), POS_W'($urandom_range(0, 127)));
      end else if ($urandom_range(0, 99) < 85) begin
        send_valid_command();
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(OP_UNUSED, random_value(), POS_W'($urandom_range(0, 127)));
          1: send_item(OP_INSERT, random_value(), POS_W'($urandom_range(fill + 1, 127)));
          2: send_item(OP_DELETE, random_value(), POS_W'($urandom_range(fill, 127)));
          default: send_item(OP_W'($urandom_range(0, 2)), random_value(),
                             POS_W'($urandom_range(0, 127)));
        endcase
      end
      if ($urandom_range(0, 99) == 0) pause_until_drained();
    end

    // Drain and let the block settle before the verdict.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/plid_pkg.sv
hw/rtl/plid_cell.sv
hw/rtl/positional_list_insert_delete_unit.sv
hw/rtl/plid_checker.sv
tb/sv/list_result_checker.sv
tb/sv/tb_positional_list_insert_delete_unit.sv
